FILE: rtl/core/psrl_pkg.sv
// Shared types, constants and helpers for the per-source rate limiter.
// No dependencies; imported by the core.
`timescale 1ns / 1ps

package psrl_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int ADDR_W  = 32;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 16;
	localparam int THR_W   = 16;
	localparam int DUR_W   = 31;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd2;
	localparam logic [DUR_W-1:0] INTERVAL_RST  = 31'd60000;
	localparam logic [DUR_W-1:0] DURATION_RST  = 31'd60000;

	// register word indexes, paddr[3:2]
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_INTERVAL  = 2'd1;
	localparam logic [1:0] REG_DURATION  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_UPDATE,
		ST_NEW
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]  last_seen;
		logic [COUNT_W-1:0] hit_count;
		logic               block_flag;
		logic [TIME_W-1:0]  release_time;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// a strictly after b, modulo 2^32
	function automatic logic later_than(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[TIME_W-1];
	endfunction

endpackage

FILE: rtl/core/psrl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module psrl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/per_source_rate_limiter_core.sv
// Per-source rate limiter: entry lookup, count/block update, config registers.
// Depends on psrl_pkg and psrl_ram (address memory and entry memory).
// Flow: a known source is found by a slot-by-slot scan (SCAN), then its entry is read
//   (READ) and updated (UPDATE); an unknown source goes from the scan, or straight when empty, to NEW.
// One packet at a time: busy until its result; results strobe one cycle, cannot be stalled.
// Reset: arst_n clears control, config to defaults and the fill count; no clearing pass.
`timescale 1ns / 1ps

module per_source_rate_limiter_core
	import psrl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// APB-style config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// packet command
	input  logic               start,
	input  logic [ADDR_W-1:0]  src_addr,
	input  logic [TIME_W-1:0]  arrival_time,
	output logic               busy,
	// result
	output logic               done,
	output logic               verdict,
	output logic               newly_blocked,
	output logic               untracked
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [THR_W-1:0] threshold_q;
	logic [DUR_W-1:0] interval_q;
	logic [DUR_W-1:0] duration_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			interval_q  <= INTERVAL_RST;
			duration_q  <= DURATION_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				REG_INTERVAL:  interval_q  <= pwdata[DUR_W-1:0];
				REG_DURATION:  duration_q  <= pwdata[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_THRESHOLD: prdata = {{(PDATA_W-THR_W){1'b0}}, threshold_q};
			REG_INTERVAL:  prdata = {{(PDATA_W-DUR_W){1'b0}}, interval_q};
			REG_DURATION:  prdata = {{(PDATA_W-DUR_W){1'b0}}, duration_q};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t             state_q, state_nxt;
	logic [IDX_W-1:0]   scan_idx_q;
	logic [CNT_W-1:0]   entries_q;
	logic [ADDR_W-1:0]  src_q;
	logic [TIME_W-1:0]  now_q;

	// ------------------------------------------------------------------
	// Memories: source addresses, and per-entry state
	// ------------------------------------------------------------------
	logic              addr_we, addr_re;
	logic [IDX_W-1:0]  addr_waddr, addr_raddr;
	logic [ADDR_W-1:0] addr_rdata;

	logic              ent_we, ent_re;
	logic [IDX_W-1:0]  ent_waddr;
	entry_t            ent_wdata, ent_rdata;
	logic [ENTRY_W-1:0] ent_rdata_raw;

	psrl_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
		.clk   (clk),
		.we    (addr_we),
		.waddr (addr_waddr),
		.wdata (src_q),
		.re    (addr_re),
		.raddr (addr_raddr),
		.rdata (addr_rdata)
	);

	psrl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (scan_idx_q),
		.rdata (ent_rdata_raw)
	);

	assign ent_rdata = entry_t'(ent_rdata_raw);

	// time tests registered between the entry read and the write-back
	logic               blocked_q;
	logic               expired_q;
	logic [COUNT_W-1:0] count_inc_q;

	logic done_q, verdict_q, newly_blocked_q, untracked_q;

	logic               accept;
	logic               match;
	logic               last_slot;
	logic               table_full;
	logic               hit_block;
	logic [TIME_W-1:0]  window_end;

	// result load and fill-count step, from the memory-control block
	logic res_load, res_verdict, res_nb, res_untracked, entries_inc;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign match      = (addr_rdata == src_q);
	assign last_slot  = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == entries_q);
	assign table_full = (entries_q >= CNT_W'(TABLE_ENTRIES));
	assign window_end = ent_rdata.last_seen + TIME_W'(interval_q);
	assign hit_block  = (count_inc_q >= threshold_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = (entries_q == '0) ? ST_NEW : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_nxt = ST_READ;
				end else if (last_slot) begin
					state_nxt = ST_NEW;
				end
			end
			ST_READ:   state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_IDLE;
			ST_NEW:    state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// memory controls and result values
	always_comb begin
		addr_re       = 1'b0;
		addr_raddr    = scan_idx_q + IDX_W'(1);
		addr_we       = 1'b0;
		addr_waddr    = IDX_W'(entries_q);
		ent_re        = 1'b0;
		ent_we        = 1'b0;
		ent_waddr     = scan_idx_q;
		ent_wdata     = ent_rdata;
		res_load      = 1'b0;
		res_verdict   = 1'b0;
		res_nb        = 1'b0;
		res_untracked = 1'b0;
		entries_inc   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				addr_re    = start;
				addr_raddr = '0;
			end
			ST_SCAN: begin
				// compare slot scan_idx_q, prefetch the next one
				addr_re = !match && !last_slot;
				ent_re  = match;
			end
			ST_READ: ;
			ST_UPDATE: begin
				res_load = 1'b1;
				if (blocked_q) begin
					res_verdict = 1'b1;
				end else begin
					ent_we              = 1'b1;
					ent_wdata.last_seen = now_q;
					ent_wdata.block_flag = 1'b0;
					if (expired_q) begin
						ent_wdata.hit_count = COUNT_W'(1);
					end else begin
						ent_wdata.hit_count = count_inc_q;
						if (hit_block) begin
							ent_wdata.block_flag   = 1'b1;
							ent_wdata.release_time = now_q + TIME_W'(duration_q);
							res_nb                 = 1'b1;
						end
					end
				end
			end
			ST_NEW: begin
				res_load = 1'b1;
				if (table_full) begin
					res_untracked = 1'b1;
				end else begin
					addr_we                = 1'b1;
					ent_we                 = 1'b1;
					ent_waddr              = IDX_W'(entries_q);
					ent_wdata.last_seen    = now_q;
					ent_wdata.hit_count    = COUNT_W'(1);
					ent_wdata.block_flag   = 1'b0;
					ent_wdata.release_time = '0;
					entries_inc            = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			entries_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= res_load;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (state_q == ST_SCAN && !match) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (entries_inc) begin
				entries_q <= entries_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q <= src_addr;
			now_q <= arrival_time;
		end
		if (state_q == ST_READ) begin
			blocked_q   <= ent_rdata.block_flag && later_than(ent_rdata.release_time, now_q);
			expired_q   <= later_than(now_q, window_end);
			count_inc_q <= (ent_rdata.hit_count == COUNT_MAX) ?
				ent_rdata.hit_count : ent_rdata.hit_count + COUNT_W'(1);
		end
		if (res_load) begin
			verdict_q       <= res_verdict;
			newly_blocked_q <= res_nb;
			untracked_q     <= res_untracked;
		end
	end

	assign done          = done_q;
	assign verdict       = verdict_q;
	assign newly_blocked = newly_blocked_q;
	assign untracked     = untracked_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count above table size");

	a_fill_only_on_new: assert property (@(posedge clk) disable iff (!arst_n)
		(entries_q != $past(entries_q)) |-> $past(state_q == ST_NEW))
		else $error("fill count moved outside an append");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict) |-> (!newly_blocked && !untracked))
		else $error("drop result carries block or untracked flag");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE || state_q == ST_NEW))
		else $error("result strobe without a finishing state");

endmodule
